// ===== src/binomial_coefficient_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Binomial coefficient unit assertion macros
// Shared macros for the concurrent assertions of the binomial coefficient unit.
// ---------------------------------------------------------------------------
`ifndef BINOMIAL_COEFFICIENT_UNIT_ASSERT_SVH
`define BINOMIAL_COEFFICIENT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bcu_pkg.sv =====
// ---------------------------------------------------------------------------
// Binomial coefficient unit package
// Types, constants and control codes shared by the unit's modules.
// ---------------------------------------------------------------------------
package bcu_pkg;

  // Largest top argument accepted in stars-and-bars mode.
  localparam int N_MAX = 63;

  // Accumulator width: holds any coefficient times the next multiplier.
  localparam int ACC_W      = 66;
  localparam int DIGIT_W    = 2;
  localparam int NUM_DIGITS = ACC_W / DIGIT_W;
  localparam int CNT_W      = $clog2(NUM_DIGITS);

  // Request kinds.
  localparam logic KIND_CHOOSE = 1'b0;
  localparam logic KIND_STARS  = 1'b1;

  // Serial core operations.
  localparam logic [1:0] OP_HOLD     = 2'd0;
  localparam logic [1:0] OP_LOAD_ONE = 2'd1;
  localparam logic [1:0] OP_MUL      = 2'd2;
  localparam logic [1:0] OP_DIV      = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [5:0] count_n;
    logic [5:0] count_r;
  } in_t;

  typedef struct packed {
    logic signed [60:0] value;
    logic               range_error;
  } out_t;

  // Control from the sequencer to the serial core.
  typedef struct packed {
    logic [1:0] op;
    logic [5:0] operand;
    logic       first;
  } core_ctl_t;

endpackage

// ===== src/bcu_serial_core.sv =====
// ---------------------------------------------------------------------------
// Binomial coefficient serial core
// Rotating accumulator that multiplies by a small factor least significant
// digit first, or divides by a small divisor most significant digit first,
// two bits per cycle.
// ---------------------------------------------------------------------------
module bcu_serial_core (
  input  logic                          clk,
  input  bcu_pkg::core_ctl_t            ctl,
  output logic [bcu_pkg::ACC_W-1:0]     acc
);
  import bcu_pkg::*;

  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [5:0]         res_r, res_nxt;
  logic [5:0]         res_in;
  logic [DIGIT_W-1:0] lo_digit, hi_digit;
  logic [7:0]         prod;
  logic [7:0]         part;
  logic [7:0]         d1, d2, d3;
  logic [7:0]         qd;
  logic [7:0]         rem;
  logic [DIGIT_W-1:0] q;

  assign acc = acc_r;

  // Digit arithmetic: carry for the multiply, remainder for the divide.
  always_comb begin
    res_in   = ctl.first ? 6'd0 : res_r;
    lo_digit = acc_r[DIGIT_W-1:0];
    hi_digit = acc_r[ACC_W-1 -: DIGIT_W];
    prod     = 8'(lo_digit) * 8'(ctl.operand) + 8'(res_in);
    part     = {1'b0, res_in[4:0], hi_digit};
    d1       = 8'(ctl.operand);
    d2       = d1 << 1;
    d3       = d1 + d2;
    if (part >= d3) begin
      q  = 2'd3;
      qd = d3;
    end else if (part >= d2) begin
      q  = 2'd2;
      qd = d2;
    end else if (part >= d1) begin
      q  = 2'd1;
      qd = d1;
    end else begin
      q  = 2'd0;
      qd = 8'd0;
    end
    rem = part - qd;
  end

  // Next accumulator and residue for the requested operation.
  always_comb begin
    acc_nxt = acc_r;
    res_nxt = res_r;
    case (ctl.op)
      OP_HOLD: begin
        acc_nxt = acc_r;
        res_nxt = res_r;
      end
      OP_LOAD_ONE: begin
        acc_nxt = ACC_W'(1);
        res_nxt = 6'd0;
      end
      OP_MUL: begin
        acc_nxt = {prod[DIGIT_W-1:0], acc_r[ACC_W-1:DIGIT_W]};
        res_nxt = prod[7:2];
      end
      OP_DIV: begin
        acc_nxt = {acc_r[ACC_W-DIGIT_W-1:0], q};
        res_nxt = rem[5:0];
      end
      default: begin
        acc_nxt = acc_r;
        res_nxt = res_r;
      end
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

endmodule

// ===== src/binomial_coefficient_unit.sv =====
// ---------------------------------------------------------------------------
// Binomial coefficient unit
// Computes C(n, r) exactly, or the low word of stars-and-bars C(n+k-1, k-1).
// ---------------------------------------------------------------------------
// Usage: a request transfers on the input channel when in_valid is high and
// in_stall is low. in_data carries the kind and the two counts. One result
// per request leaves on the output channel when out_valid is high and
// out_stall is low.
// Steps: the unit runs s steps, where s is min(r, n - r) of the coefficient
// actually evaluated (at most 31). Each of the s steps runs one multiply and
// one exact divide through a 66-bit accumulator at two bits per cycle.
// Throughput: one request at a time; the next request is taken as soon as the
// previous result is in the output register, even while that result waits.
// Special cases (r > n, zero bins, range error) skip the multiply and divide.
// Reset: rst_n low for one clock empties the block; out_valid falls low.
// A stalled result holds its value until it transfers; a finished request
// waits inside the block while the output register is still occupied.
// ---------------------------------------------------------------------------
module binomial_coefficient_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bcu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bcu_pkg::out_t out_data
);
  import bcu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r;

  logic             kind_r, err_r, zero_r;
  logic [5:0]       mul_r, div_r, steps_r;

  logic             in_xfer, out_load, last_digit;
  logic [6:0]       top_sum;
  logic [5:0]       req_n, req_r, req_diff, req_steps;
  logic             req_zero, req_err;
  logic signed [60:0] value_nxt;

  core_ctl_t        ctl;
  logic [ACC_W-1:0] acc;

  bcu_serial_core u_core (
    .clk (clk),
    .ctl (ctl),
    .acc (acc)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign last_digit = (cnt_r == CNT_W'(NUM_DIGITS - 1));
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Request decode: special cases and the symmetric step count.
  always_comb begin
    top_sum  = 7'(in_data.count_n) + 7'(in_data.count_r) - 7'd1;
    req_n    = in_data.count_n;
    req_r    = in_data.count_r;
    req_zero = 1'b0;
    req_err  = 1'b0;
    if (in_data.kind == KIND_CHOOSE) begin
      req_zero = (in_data.count_r > in_data.count_n);
    end else if (in_data.count_r == 6'd0) begin
      req_zero = 1'b1;
    end else if (top_sum > 7'(N_MAX)) begin
      req_zero = 1'b1;
      req_err  = 1'b1;
    end else begin
      req_n = top_sum[5:0];
      req_r = in_data.count_r - 6'd1;
    end
    req_diff  = req_n - req_r;
    req_steps = (req_r > req_diff) ? req_diff : req_r;
  end

  // Sequencer: one multiply pass then one divide pass per step.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ctl.op      = OP_HOLD;
    ctl.operand = mul_r;
    ctl.first   = (cnt_r == '0);
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          ctl.op    = OP_LOAD_ONE;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cnt_nxt = '0;
        if (zero_r || (div_r > steps_r)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        ctl.op  = OP_MUL;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last_digit) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        ctl.op      = OP_DIV;
        ctl.operand = div_r;
        cnt_nxt     = cnt_r + CNT_W'(1);
        if (last_digit) begin
          cnt_nxt   = '0;
          state_nxt = S_STEP;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register occupancy.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Final value: stars-and-bars mode keeps the low word, sign-extended.
  always_comb begin
    if (zero_r) begin
      value_nxt = '0;
    end else if (kind_r == KIND_STARS) begin
      value_nxt = {{29{acc[31]}}, acc[31:0]};
    end else begin
      value_nxt = acc[60:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r  <= in_data.kind;
      err_r   <= req_err;
      zero_r  <= req_zero;
      mul_r   <= req_n;
      div_r   <= 6'd1;
      steps_r <= req_steps;
    end else if ((state_r == S_DIV) && last_digit) begin
      mul_r <= mul_r - 6'd1;
      div_r <= div_r + 6'd1;
    end
    if (out_load) begin
      out_data_r.value       <= value_nxt;
      out_data_r.range_error <= err_r;
    end
  end

endmodule

// ===== src/bcu_checker.sv =====
// ---------------------------------------------------------------------------
// Binomial coefficient unit checker
// Port-level assertions on the unit's channels, bound to the top level.
// ---------------------------------------------------------------------------
`include "binomial_coefficient_unit_assert.svh"

module bcu_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input bcu_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input bcu_pkg::out_t out_data
);
  import bcu_pkg::*;

  // A held result keeps its payload until it transfers.
  `BCU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // The block works on one request at a time.
  `BCU_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "request taken while busy")

  // A range error always carries a zero value.
  `BCU_ASSERT_NOW(a_err_zero, out_valid && out_data.range_error, out_data.value == 61'sd0, "range error with nonzero value")

  // A negative value only comes from a sign-extended low word.
  `BCU_ASSERT_NOW(a_sign_ext, out_valid && out_data.value[60], &out_data.value[60:31], "negative value not sign-extended")

endmodule

bind binomial_coefficient_unit bcu_checker u_bcu_checker (.*);

// ===== test/binomial_coefficient_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Binomial coefficient unit testbench
// Drives choose and stars-and-bars requests through the valid/stall input
// channel and checks each result against an exact coefficient predictor. A
// short directed table covers the extremes and special cases. Random requests
// follow under three idling profiles, with one long receiver hold-off that
// backs the unit up.
// ----------------------------------------------------------------------------
module binomial_coefficient_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcu_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 11;
  localparam int ITEMS_PER_RUN = 75;
  localparam int HOLD_CYCLES   = 5000;
  localparam int DRAIN_CYCLES  = 2200;
  localparam int MAX_REPORTS   = 10;

  // One pending coefficient, with the request that caused it.
  typedef struct packed {
    in_t  req;
    out_t res;
  } coef_expect_t;

  // One directed request; the result is typed in only when known is set.
  typedef struct packed {
    in_t  req;
    logic known;
    out_t res;
  } coef_row_t;

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  in_t   in_data   = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  coef_expect_t coef_expect_q[$];
  coef_row_t    directed_rows[$];
  int           fail_count = 0;
  int           idle_phase = 0;
  int           send_idle_pct[3] = '{16, 80, 0};
  int           recv_idle_pct[3] = '{80, 16, 0};

  binomial_coefficient_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Free-running clock.
  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Exact C(n, r) by a running product that divides exactly at every step.
  function automatic logic [63:0] binom_exact(input int unsigned n, input int unsigned r);
    logic [127:0] acc;
    int unsigned  steps;
    if (r > n) begin
      return 64'd0;
    end
    steps = (r > n - r) ? n - r : r;
    acc   = 128'd1;
    for (int i = 0; i < steps; i++) begin
      acc = acc * (n - i) / (i + 1);
    end
    return acc[63:0];
  endfunction

  // Expected result of one request.
  function automatic out_t predict_coef(input in_t req);
    out_t        res;
    logic [63:0] coef;
    int          top;
    res.value       = '0;
    res.range_error = 1'b0;
    if (req.kind == KIND_CHOOSE) begin
      coef      = binom_exact(req.count_n, req.count_r);
      res.value = coef[60:0];
    end else if (req.count_r != 6'd0) begin
      top = int'(req.count_n) + int'(req.count_r) - 1;
      if (top > N_MAX) begin
        res.range_error = 1'b1;
      end else begin
        // Only the low 32 bits survive, sign-extended.
        coef      = binom_exact(top, int'(req.count_r) - 1);
        res.value = {{29{coef[31]}}, coef[31:0]};
      end
    end
    return res;
  endfunction

  function automatic void add_row(input logic kind, input int n, input int r,
                                  input logic known, input longint value,
                                  input logic err);
    coef_row_t row;
    row.req.kind        = kind;
    row.req.count_n     = n[5:0];
    row.req.count_r     = r[5:0];
    row.known           = known;
    row.res.value       = value[60:0];
    row.res.range_error = err;
    directed_rows.push_back(row);
  endfunction

  // Random request: mostly in-range work, the rest raw field noise.
  function automatic in_t random_request();
    in_t req;
    int  pick;
    pick        = $urandom_range(99);
    req.kind    = 1'($urandom_range(1));
    req.count_n = 6'($urandom_range(63));
    req.count_r = 6'($urandom_range(63));
    if (pick < 45) begin
      req.kind = KIND_CHOOSE;
    end else if (pick < 85) begin
      // Stars and bars with the top argument inside the supported range.
      req.kind    = KIND_STARS;
      req.count_r = 6'($urandom_range(63, 1));
      req.count_n = 6'($urandom_range(64 - int'(req.count_r), 0));
    end
    return req;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  // Offers one request, waits for its transfer and records the expectation.
  task automatic offer_request(input in_t req, input out_t res);
    coef_expect_t pending;
    while ($urandom_range(99) < send_idle_pct[idle_phase]) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending.req = req;
    pending.res = res;
    coef_expect_q.push_back(pending);
  endtask

  // Result side: checks every transfer and drives the stall pattern.
  initial begin : result_side
    coef_expect_t pending;
    int           hold_left;
    bit           hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (coef_expect_q.size() == 0) begin
          note_failure($sformatf("Unexpected result transfer: value %0d range_error %0b",
                                 out_data.value, out_data.range_error));
        end else begin
          pending = coef_expect_q.pop_front();
          if (out_data.value !== pending.res.value) begin
            note_failure($sformatf(
              "value mismatch kind %0b n %0d r %0d: expected %0d, got %0d",
              pending.req.kind, pending.req.count_n, pending.req.count_r,
              pending.res.value, out_data.value));
          end
          if (out_data.range_error !== pending.res.range_error) begin
            note_failure($sformatf(
              "range_error mismatch kind %0b n %0d r %0d: expected %0b, got %0b",
              pending.req.kind, pending.req.count_n, pending.req.count_r,
              pending.res.range_error, out_data.range_error));
          end
        end
      end
      // A long hold-off at the start of the no-idle phase fills the unit.
      if (idle_phase == 2 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct[idle_phase]);
      end
    end
  end

  // Request side: reset, directed table, then random requests per phase.
  initial begin : request_side
    coef_row_t row;
    in_t       req;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Choose mode extremes and the r > n case.
    add_row(KIND_CHOOSE, 0, 0, 1'b1, 1, 1'b0);
    add_row(KIND_CHOOSE, 63, 63, 1'b1, 1, 1'b0);
    add_row(KIND_CHOOSE, 63, 0, 1'b1, 1, 1'b0);
    add_row(KIND_CHOOSE, 0, 63, 1'b1, 0, 1'b0);
    add_row(KIND_CHOOSE, 5, 6, 1'b1, 0, 1'b0);
    add_row(KIND_CHOOSE, 63, 1, 1'b1, 63, 1'b0);
    add_row(KIND_CHOOSE, 63, 62, 1'b1, 63, 1'b0);
    add_row(KIND_CHOOSE, 63, 31, 1'b0, 0, 1'b0);
    add_row(KIND_CHOOSE, 63, 32, 1'b0, 0, 1'b0);
    add_row(KIND_CHOOSE, 42, 21, 1'b0, 0, 1'b0);
    // Stars and bars: zero bins, range errors and the edge of the range.
    add_row(KIND_STARS, 5, 0, 1'b1, 0, 1'b0);
    add_row(KIND_STARS, 63, 0, 1'b1, 0, 1'b0);
    add_row(KIND_STARS, 0, 0, 1'b1, 0, 1'b0);
    add_row(KIND_STARS, 63, 63, 1'b1, 0, 1'b1);
    add_row(KIND_STARS, 63, 2, 1'b1, 0, 1'b1);
    add_row(KIND_STARS, 2, 63, 1'b1, 0, 1'b1);
    add_row(KIND_STARS, 63, 1, 1'b1, 1, 1'b0);
    add_row(KIND_STARS, 62, 2, 1'b1, 63, 1'b0);
    add_row(KIND_STARS, 0, 1, 1'b1, 1, 1'b0);
    add_row(KIND_STARS, 1, 63, 1'b1, 63, 1'b0);
    add_row(KIND_STARS, 0, 63, 1'b1, 1, 1'b0);
    // Large stars-and-bars counts where the 32-bit truncation matters.
    add_row(KIND_STARS, 32, 32, 1'b0, 0, 1'b0);
    add_row(KIND_STARS, 31, 33, 1'b0, 0, 1'b0);
    add_row(KIND_STARS, 40, 20, 1'b0, 0, 1'b0);
    add_row(KIND_STARS, 21, 43, 1'b0, 0, 1'b0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      offer_request(row.req, row.known ? row.res : predict_coef(row.req));
    end

    // Random requests under each idling profile in turn.
    for (int p = 0; p < 3; p++) begin
      idle_phase = p;
      for (int i = 0; i < ITEMS_PER_RUN; i++) begin
        req = random_request();
        offer_request(req, predict_coef(req));
      end
    end
    in_valid <= 1'b0;

    // Let every result arrive, then watch for stray transfers.
    while (coef_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && coef_expect_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
